FILE: src/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types, operation codes and saturation helpers for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

  // operation codes
  localparam logic [3:0] OP_ADD      = 4'd0;
  localparam logic [3:0] OP_SUB      = 4'd1;
  localparam logic [3:0] OP_MUL      = 4'd2;
  localparam logic [3:0] OP_DIV      = 4'd3;
  localparam logic [3:0] OP_MIN      = 4'd4;
  localparam logic [3:0] OP_MAX      = 4'd5;
  localparam logic [3:0] OP_INC      = 4'd6;
  localparam logic [3:0] OP_DEC      = 4'd7;
  localparam logic [3:0] OP_TO_INT   = 4'd8;
  localparam logic [3:0] OP_FROM_INT = 4'd9;

  // quotient bits produced by the divider chain, one per stage
  localparam int DIV_STEPS = 32;
  // front stages + divider steps + output stage
  localparam int LATENCY   = 3 + DIV_STEPS + 1;

  localparam logic [31:0] POS_LIMIT = 32'h7fff_ffff;
  localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

  // item state carried down the pipeline
  typedef struct packed {
    logic [3:0]  op;
    logic        lt;
    logic        gt;
    logic        eq;
    logic        dz;
    logic        ovf;
    logic        neg;
    logic        big;
    logic [31:0] res;
    logic [63:0] pmag;
    logic [31:0] rem;
    logic [31:0] num_lo;
    logic [31:0] den;
    logic [31:0] quo;
  } fpa_item_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] val;
  } fpa_sat_t;

  // clamp a signed 64-bit value to the 32-bit range
  function automatic fpa_sat_t sat_s64(input logic signed [63:0] v);
    fpa_sat_t s;
    s.ovf = 1'b0;
    s.val = v[31:0];
    if (v > 64'sh0000_0000_7fff_ffff) begin
      s.ovf = 1'b1;
      s.val = POS_LIMIT;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      s.ovf = 1'b1;
      s.val = NEG_LIMIT;
    end
    return s;
  endfunction

  // clamp a magnitude with sign to the 32-bit range
  function automatic fpa_sat_t sat_mag(input logic [63:0] m, input logic neg);
    fpa_sat_t s;
    logic [63:0] lim;
    lim   = neg ? {32'd0, NEG_LIMIT} : {32'd0, POS_LIMIT};
    s.ovf = 1'b0;
    s.val = neg ? (~m[31:0] + 32'd1) : m[31:0];
    if (m > lim) begin
      s.ovf = 1'b1;
      s.val = neg ? NEG_LIMIT : POS_LIMIT;
    end
    return s;
  endfunction

endpackage

FILE: src/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front
// Input register, simple operations and multiplier, then divider set-up.
// ----------------------------------------------------------------------------
module fpa_front #(
  parameter int FRAC_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [3:0]          op_i,
  input  logic signed [31:0]  a_i,
  input  logic signed [31:0]  b_i,
  output logic                valid_o,
  output fpa_pkg::fpa_item_t  item_o
);

  // stage 1: input register
  logic               v1_q;
  logic [3:0]         op1_q;
  logic signed [31:0] a1_q, b1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q <= op_i;
    a1_q  <= a_i;
    b1_q  <= b_i;
  end

  // stage 2: flags, simple ops, product
  logic               v2_q;
  logic [3:0]         op2_q;
  logic signed [31:0] a2_q, b2_q;
  logic signed [63:0] prod2_q;
  logic [31:0]        res2_q;
  logic               ovf2_q, lt2_q, gt2_q, eq2_q;

  logic [31:0]        res2_d;
  logic               ovf2_d;
  logic signed [63:0] a64, b64;
  fpa_pkg::fpa_sat_t  s;

  always_comb begin
    a64    = 64'(a1_q);
    b64    = 64'(b1_q);
    res2_d = 32'd0;
    ovf2_d = 1'b0;
    s      = '0;
    case (op1_q)
      fpa_pkg::OP_ADD: begin
        s = fpa_pkg::sat_s64(a64 + b64);
        res2_d = s.val;
        ovf2_d = s.ovf;
      end
      fpa_pkg::OP_SUB: begin
        s = fpa_pkg::sat_s64(a64 - b64);
        res2_d = s.val;
        ovf2_d = s.ovf;
      end
      fpa_pkg::OP_MIN: res2_d = (a1_q < b1_q) ? a1_q : b1_q;
      fpa_pkg::OP_MAX: res2_d = (a1_q > b1_q) ? a1_q : b1_q;
      fpa_pkg::OP_INC: begin
        s = fpa_pkg::sat_s64(a64 + 64'sd1);
        res2_d = s.val;
        ovf2_d = s.ovf;
      end
      fpa_pkg::OP_DEC: begin
        s = fpa_pkg::sat_s64(a64 - 64'sd1);
        res2_d = s.val;
        ovf2_d = s.ovf;
      end
      fpa_pkg::OP_TO_INT: res2_d = a1_q >>> FRAC_BITS;
      fpa_pkg::OP_FROM_INT: begin
        s = fpa_pkg::sat_s64(a64 <<< FRAC_BITS);
        res2_d = s.val;
        ovf2_d = s.ovf;
      end
      default: res2_d = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op2_q   <= op1_q;
    a2_q    <= a1_q;
    b2_q    <= b1_q;
    prod2_q <= a64 * b64;
    res2_q  <= res2_d;
    ovf2_q  <= ovf2_d;
    lt2_q   <= (a1_q < b1_q);
    gt2_q   <= (a1_q > b1_q);
    eq2_q   <= (a1_q == b1_q);
  end

  // stage 3: product magnitude and divider set-up
  logic [31:0]        maga, magb;
  logic [63:0]        num64;
  fpa_pkg::fpa_item_t item_d;

  always_comb begin
    maga        = a2_q[31] ? (~a2_q + 32'd1) : a2_q;
    magb        = b2_q[31] ? (~b2_q + 32'd1) : b2_q;
    num64       = {32'd0, maga} << FRAC_BITS;
    item_d      = '0;
    item_d.op   = op2_q;
    item_d.lt   = lt2_q;
    item_d.gt   = gt2_q;
    item_d.eq   = eq2_q;
    item_d.ovf  = ovf2_q;
    item_d.res  = res2_q;
    item_d.dz   = (op2_q == fpa_pkg::OP_DIV) && (b2_q == 32'sd0);
    item_d.pmag = prod2_q[63] ? (~prod2_q + 64'd1) : prod2_q;
    item_d.neg  = (op2_q == fpa_pkg::OP_MUL) ? prod2_q[63] : (a2_q[31] ^ b2_q[31]);
    item_d.big  = (num64[63:32] >= magb);
    item_d.rem  = num64[63:32];
    item_d.num_lo = num64[31:0];
    item_d.den  = magb;
    item_d.quo  = 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    item_o <= item_d;
  end

endmodule

FILE: src/fpa_div_step.sv
// ----------------------------------------------------------------------------
// fpa_div_step
// One restoring division step: produces one quotient bit per stage.
// ----------------------------------------------------------------------------
module fpa_div_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  fpa_pkg::fpa_item_t  item_i,
  output logic                valid_o,
  output fpa_pkg::fpa_item_t  item_o
);

  logic [32:0]        part;
  logic               qbit;
  fpa_pkg::fpa_item_t item_d;

  // shift in the next numerator bit, subtract when it fits
  always_comb begin
    part          = {item_i.rem, item_i.num_lo[31]};
    qbit          = (part >= {1'b0, item_i.den});
    item_d        = item_i;
    item_d.rem    = qbit ? 32'(part - {1'b0, item_i.den}) : part[31:0];
    item_d.num_lo = {item_i.num_lo[30:0], 1'b0};
    item_d.quo    = {item_i.quo[30:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_o <= item_d;
  end

endmodule

FILE: src/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back
// Rounding and saturation of multiply and divide, output register.
// ----------------------------------------------------------------------------
module fpa_back #(
  parameter int FRAC_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  fpa_pkg::fpa_item_t  item_i,
  output logic                valid_o,
  output logic [31:0]         res_o,
  output logic                lt_o,
  output logic                gt_o,
  output logic                eq_o,
  output logic                dz_o,
  output logic                ovf_o
);

  localparam int          RND_SH = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;
  localparam logic [63:0] RND    = (FRAC_BITS > 0) ? (64'd1 << RND_SH) : 64'd0;

  logic [63:0]       mmag;
  logic              rbit;
  logic [63:0]       qmag;
  fpa_pkg::fpa_sat_t smul, sdiv;
  logic [31:0]       res_d;
  logic              ovf_d;

  // round half away from zero, then clamp
  always_comb begin
    mmag  = (item_i.pmag + RND) >> FRAC_BITS;
    rbit  = ({item_i.rem, 1'b0} >= {1'b0, item_i.den});
    qmag  = {31'd0, ({1'b0, item_i.quo} + {32'd0, rbit})};
    smul  = fpa_pkg::sat_mag(mmag, item_i.neg);
    sdiv  = fpa_pkg::sat_mag(qmag, item_i.neg);
    res_d = item_i.res;
    ovf_d = item_i.ovf;
    case (item_i.op)
      fpa_pkg::OP_MUL: begin
        res_d = smul.val;
        ovf_d = smul.ovf;
      end
      fpa_pkg::OP_DIV: begin
        if (item_i.dz) begin
          res_d = 32'd0;
          ovf_d = 1'b0;
        end else if (item_i.big) begin
          res_d = item_i.neg ? fpa_pkg::NEG_LIMIT : fpa_pkg::POS_LIMIT;
          ovf_d = 1'b1;
        end else begin
          res_d = sdiv.val;
          ovf_d = sdiv.ovf;
        end
      end
      default: begin
        res_d = item_i.res;
        ovf_d = item_i.ovf;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_o <= res_d;
    ovf_o <= ovf_d;
    lt_o  <= item_i.lt;
    gt_o  <= item_i.gt;
    eq_o  <= item_i.eq;
    dz_o  <= item_i.dz;
  end

endmodule

FILE: src/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed fixed-point ALU, fully pipelined, one item per clock.
// ----------------------------------------------------------------------------
// An item is taken on every cycle that start is high; busy is never
// raised. Every item, whatever its operation, passes through 36 register
// stages (3 front stages, 32 divider stages at one quotient bit each, 1
// rounding and output stage), in order. Its result is shown on
// result_value_o, with result_valid_o high, once the output register holds it.
// The result is shown for one cycle only and must be captured then: the
// receiver cannot stall.
module fixed_point_alu #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         req_type_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output logic               result_valid_o,
  output logic signed [31:0] result_value_o,
  output logic               a_less_o,
  output logic               a_greater_o,
  output logic               a_equal_o,
  output logic               div_zero_o,
  output logic               overflowed_o
);

  // pipeline never blocks
  assign busy = 1'b0;

  fpa_pkg::fpa_item_t              chain [0:fpa_pkg::DIV_STEPS];
  logic [fpa_pkg::DIV_STEPS:0]     vchain;
  logic [31:0]                     res;

  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .op_i    (req_type_i),
    .a_i     (operand_a_i),
    .b_i     (operand_b_i),
    .valid_o (vchain[0]),
    .item_o  (chain[0])
  );

  // divider chain
  for (genvar i = 0; i < fpa_pkg::DIV_STEPS; i++) begin : g_div
    fpa_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vchain[i]),
      .item_i  (chain[i]),
      .valid_o (vchain[i+1]),
      .item_o  (chain[i+1])
    );
  end

  fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vchain[fpa_pkg::DIV_STEPS]),
    .item_i  (chain[fpa_pkg::DIV_STEPS]),
    .valid_o (result_valid_o),
    .res_o   (res),
    .lt_o    (a_less_o),
    .gt_o    (a_greater_o),
    .eq_o    (a_equal_o),
    .dz_o    (div_zero_o),
    .ovf_o   (overflowed_o)
  );

  assign result_value_o = res;

endmodule

FILE: src/fpa_checker.sv
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks on the fixed-point ALU, bound to the top level.
// ----------------------------------------------------------------------------
module fpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_valid_o,
  input logic [31:0] result_value_o,
  input logic        a_less_o,
  input logic        a_greater_o,
  input logic        a_equal_o,
  input logic        div_zero_o,
  input logic        overflowed_o
);

  // every result traces back to an item taken a fixed time earlier
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, fpa_pkg::LATENCY))
    else $error("result without matching item");

  // exactly one ordering flag per result
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $onehot({a_less_o, a_greater_o, a_equal_o}))
    else $error("comparison flags inconsistent");

  // divide by zero gives zero and no overflow
  a_dz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && div_zero_o) |-> (result_value_o == 32'd0 && !overflowed_o))
    else $error("divide by zero result wrong");

  // saturated results sit on a bound
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && overflowed_o) |->
      (result_value_o == fpa_pkg::POS_LIMIT || result_value_o == fpa_pkg::NEG_LIMIT))
    else $error("overflow not at a bound");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_value_o (result_value_o),
  .a_less_o       (a_less_o),
  .a_greater_o    (a_greater_o),
  .a_equal_o      (a_equal_o),
  .div_zero_o     (div_zero_o),
  .overflowed_o   (overflowed_o)
);
